@@ rtl/prim_mst_total_cost_defines.svh @@
// Assertion macros for the RTL file that carries checks.
`ifndef PRIM_MST_TOTAL_COST_DEFINES_SVH
`define PRIM_MST_TOTAL_COST_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define PMST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next cycle.
`define PMST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pmst_pkg.sv @@
package pmst_pkg;

    localparam int ID_W    = 11;
    localparam int COST_W  = 32;
    localparam int TOTAL_W = 48;
    localparam int ST_W    = 2;
    localparam int EDGE_W  = 2 * ID_W + COST_W;
    localparam int IN_DATA_W  = ((EDGE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((TOTAL_W + ST_W + 7) / 8) * 8;

    localparam logic signed [COST_W-1:0] COST_NEVER = 32'sh7FFF_FFFF;

    typedef logic [ST_W-1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_DISCONN  = 2'd1;
    localparam t_status ST_BAD_ID   = 2'd2;
    localparam t_status ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic [ID_W-1:0]          v;
        logic [ID_W-1:0]          u;
    } t_edge;

    typedef struct packed {
        logic init;
        logic valid;
    } t_sel_ctl;

    typedef struct packed {
        logic                     found;
        logic signed [COST_W-1:0] cost;
        logic [ID_W-1:0]          pick;
    } t_sel_res;

endpackage

@@ rtl/prim_mst_total_cost.sv @@
// Edges load at one transaction per cycle while the block is in S_LOAD.
// After the tlast edge the block clears the tree map of n nodes (n = node count),
// then runs n-1 rounds, each a scan of the E stored edges plus a pick.
// It skips to the result on a loading error or with fewer than two nodes.
// An edge without tlast gives no result.
// Synchronous active-low reset clears control state; node count resets to 2.
`include "prim_mst_total_cost_defines.svh"

module prim_mst_total_cost
    import pmst_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [ID_W-1:0]       i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // edge_u [10:0], edge_v [21:11], edge_cost [53:22], zero fill above
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // total_cost [47:0], status [49:48], zero fill above
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int NW = $clog2(MAX_NODES);
    localparam logic [CW-1:0] EDGE_CAP = CW'(MAX_EDGES);
    localparam logic [31:0]   NODE_CAP = 32'(MAX_NODES);

    typedef enum logic [4:0] {
        S_LOAD      = 5'b00001,
        S_CLEAR     = 5'b00010,
        S_SCAN      = 5'b00100,
        S_ROUND_END = 5'b01000,
        S_EMIT      = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [ID_W-1:0]           r_node_count;
    logic [CW-1:0]             r_count, n_count;
    t_status                   r_err, n_err;
    logic signed [TOTAL_W-1:0] r_total, n_total;
    logic [ID_W-1:0]           r_clr_cnt, n_clr_cnt;
    logic [ID_W-1:0]           r_round, n_round;
    logic [CW-1:0]             r_rd_idx, n_rd_idx;
    logic                      r_v1, r_v2;
    t_edge                     r_e2;
    logic signed [TOTAL_W-1:0] r_res_total, n_res_total;
    t_status                   r_res_status, n_res_status;
    logic                      r_out_valid;
    logic signed [TOTAL_W-1:0] r_out_total;
    t_status                   r_out_status;

    logic                      s_acc;
    t_edge                     in_edge;
    logic [ID_W-1:0]           n_eff;
    logic                      ovf, bad_id, store_we;
    t_status                   err_in, err_next;
    logic                      issue, scan_done, emit_go;
    logic signed [TOTAL_W-1:0] total_sum;
    t_edge                     rd_edge;
    logic                      vis_a, vis_b;
    logic                      tm_we, tm_wdata;
    logic [NW-1:0]             tm_waddr;
    t_sel_ctl                  sel_ctl;
    t_sel_res                  sel_res;

    assign n_eff = ({21'd0, r_node_count} > NODE_CAP) ? NODE_CAP[ID_W-1:0] : r_node_count;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_LOAD);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign in_edge     = t_edge'(i_s_tdata[EDGE_W-1:0]);

    assign ovf      = (r_count == EDGE_CAP);
    assign bad_id   = (in_edge.u == '0) || (in_edge.v == '0) ||
                      (in_edge.u > n_eff) || (in_edge.v > n_eff);
    assign store_we = s_acc && !ovf && !bad_id;
    assign err_in   = ovf ? ST_OVERFLOW : (bad_id ? ST_BAD_ID : ST_OK);
    assign err_next = (s_acc && (err_in > r_err)) ? err_in : r_err;

    assign issue     = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign scan_done = (r_state == S_SCAN) && !issue && !r_v1 && !r_v2;
    assign emit_go   = !r_out_valid || i_m_tready;
    assign total_sum = r_total + TOTAL_W'(sel_res.cost);

    pmst_edge_store #(
        .DEPTH (MAX_EDGES),
        .AW    (EW)
    ) u_edge_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[EW-1:0]),
        .i_wdata (in_edge),
        .i_raddr (r_rd_idx[EW-1:0]),
        .o_rdata (rd_edge)
    );

    always_comb begin
        tm_we    = 1'b0;
        tm_waddr = NW'(r_clr_cnt);
        tm_wdata = (r_clr_cnt == '0);
        if (r_state == S_CLEAR) begin
            tm_we = 1'b1;
        end else if ((r_state == S_ROUND_END) && sel_res.found) begin
            tm_we    = 1'b1;
            tm_waddr = NW'(sel_res.pick - ID_W'(1));
            tm_wdata = 1'b1;
        end
    end

    pmst_tree_map #(
        .DEPTH (MAX_NODES),
        .AW    (NW)
    ) u_tree_map (
        .i_clk     (i_clk),
        .i_we      (tm_we),
        .i_waddr   (tm_waddr),
        .i_wdata   (tm_wdata),
        .i_raddr_a (NW'(rd_edge.u - ID_W'(1))),
        .i_raddr_b (NW'(rd_edge.v - ID_W'(1))),
        .o_rdata_a (vis_a),
        .o_rdata_b (vis_b)
    );

    assign sel_ctl.init  = (r_state == S_CLEAR) || (r_state == S_ROUND_END);
    assign sel_ctl.valid = r_v2;

    pmst_best_sel u_best_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_in_a  (vis_a),
        .i_in_b  (vis_b),
        .i_edge  (r_e2),
        .o_res   (sel_res)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_total      = r_total;
        n_clr_cnt    = r_clr_cnt;
        n_round      = r_round;
        n_rd_idx     = r_rd_idx;
        n_res_total  = r_res_total;
        n_res_status = r_res_status;
        if (issue) begin
            n_rd_idx = r_rd_idx + CW'(1);
        end
        case (r_state)
            S_LOAD: begin
                if (s_acc) begin
                    n_err = err_next;
                    if (store_we) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_s_tlast) begin
                        n_res_total  = '0;
                        n_res_status = err_next;
                        n_total      = '0;
                        n_clr_cnt    = '0;
                        if ((err_next != ST_OK) || (n_eff < ID_W'(2))) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_CLEAR;
                        end
                    end
                end
            end
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + ID_W'(1);
                if (r_clr_cnt == n_eff - ID_W'(1)) begin
                    n_rd_idx = '0;
                    n_round  = ID_W'(1);
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_ROUND_END;
                end
            end
            S_ROUND_END: begin
                if (!sel_res.found) begin
                    n_res_total  = '0;
                    n_res_status = ST_DISCONN;
                    n_state      = S_EMIT;
                end else begin
                    n_total = total_sum;
                    if (r_round == n_eff - ID_W'(1)) begin
                        n_res_total  = total_sum;
                        n_res_status = ST_OK;
                        n_state      = S_EMIT;
                    end else begin
                        n_round  = r_round + ID_W'(1);
                        n_rd_idx = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_count = '0;
                    n_err   = ST_OK;
                    n_total = '0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_node_count <= ID_W'(2);
            r_count      <= '0;
            r_err        <= ST_OK;
            r_total      <= '0;
            r_clr_cnt    <= '0;
            r_round      <= '0;
            r_rd_idx     <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_err     <= n_err;
            r_total   <= n_total;
            r_clr_cnt <= n_clr_cnt;
            r_round   <= n_round;
            r_rd_idx  <= n_rd_idx;
            r_v1      <= issue;
            r_v2      <= r_v1;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
            if ((r_state == S_EMIT) && emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e2         <= rd_edge;
        r_res_total  <= n_res_total;
        r_res_status <= n_res_status;
        if ((r_state == S_EMIT) && emit_go) begin
            r_out_total  <= r_res_total;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - TOTAL_W - ST_W){1'b0}}, r_out_status, r_out_total};

    `PMST_ASSERT(a_count_cap, r_count <= EDGE_CAP, "stored edge count above capacity")
    `PMST_ASSERT(a_round_drained, (r_state == S_ROUND_END) |-> (!r_v1 && !r_v2),
        "scan pipeline busy at round end")
    `PMST_ASSERT(a_load_drained, (r_state == S_LOAD) |-> (!r_v1 && !r_v2),
        "scan pipeline busy while loading")
    `PMST_ASSERT(a_err_total, (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_total == '0),
        "nonzero total with error status")
    `PMST_ASSERT_NEXT(a_emit_clears, (r_state == S_EMIT) && emit_go,
        (r_count == '0) && (r_err == ST_OK) && (r_state == S_LOAD),
        "graph state not cleared after result")

endmodule

@@ rtl/pmst_edge_store.sv @@
module pmst_edge_store
    import pmst_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_edge         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_edge         o_rdata
);

    t_edge r_mem [DEPTH];
    t_edge r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pmst_tree_map.sv @@
module pmst_tree_map
    import pmst_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic          o_rdata_a,
    output logic          o_rdata_b
);

    logic r_mem [DEPTH];
    logic r_rdata_a;
    logic r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/pmst_best_sel.sv @@
module pmst_best_sel
    import pmst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_sel_ctl i_ctl,
    input  logic     i_in_a,
    input  logic     i_in_b,
    input  t_edge    i_edge,
    output t_sel_res o_res
);

    logic                     r_found;
    logic signed [COST_W-1:0] r_best;
    logic [ID_W-1:0]          r_pick;
    logic                     take;

    // An edge is a candidate when exactly one endpoint is in the tree and it is
    // strictly cheaper than the best so far, so the first of equal costs wins.
    assign take = i_ctl.valid && (i_in_a != i_in_b) && (i_edge.cost < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_best  <= COST_NEVER;
        end else if (i_ctl.init) begin
            r_found <= 1'b0;
            r_best  <= COST_NEVER;
        end else if (take) begin
            r_found <= 1'b1;
            r_best  <= i_edge.cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pick <= i_in_a ? i_edge.v : i_edge.u;
        end
    end

    assign o_res.found = r_found;
    assign o_res.cost  = r_best;
    assign o_res.pick  = r_pick;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    import pmst_pkg::*;

    localparam int MAX_NODES     = 1024;
    localparam int MAX_EDGES     = 4096;
    localparam int HOLD_CYCLES   = 2500;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 1170;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_ID        = (1 << ID_W) - 1;

    typedef struct {
        logic [ID_W-1:0]          u;
        logic [ID_W-1:0]          v;
        logic signed [COST_W-1:0] cost;
        logic                     last;
    } edge_in_t;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        t_status            status;
    } mst_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [ID_W-1:0]       i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    edge_in_t    edges_to_send[$];
    edge_in_t    stored_graph[$];
    mst_result_t mst_results_due[$];
    int unsigned nodes_cfg = 2;
    t_status     load_err = ST_OK;
    int unsigned mismatch_count = 0;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned pattern_left = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;
    logic        long_hold_req = 1'b0;
    logic        long_hold_done = 1'b0;

    prim_mst_total_cost #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Prim's algorithm from node 1 over the stored edges of the current graph.
    function automatic void prim_cost(input int unsigned n, output longint sum,
                                      output t_status st);
        bit          in_tree[MAX_NODES+1];
        longint      best;
        int unsigned pick;
        bit          found;
        bit          a;
        bit          b;
        sum = 0;
        st = ST_OK;
        if (n < 2) begin
            return;
        end
        foreach (in_tree[i]) begin
            in_tree[i] = 1'b0;
        end
        in_tree[1] = 1'b1;
        for (int unsigned r = 1; r < n; r++) begin
            best = longint'(COST_NEVER);
            pick = 0;
            found = 1'b0;
            foreach (stored_graph[i]) begin
                a = in_tree[stored_graph[i].u];
                b = in_tree[stored_graph[i].v];
                if (a != b && longint'(stored_graph[i].cost) < best) begin
                    best = longint'(stored_graph[i].cost);
                    pick = a ? 32'(stored_graph[i].v) : 32'(stored_graph[i].u);
                    found = 1'b1;
                end
            end
            if (!found) begin
                sum = 0;
                st = ST_DISCONN;
                return;
            end
            in_tree[pick] = 1'b1;
            sum += best;
        end
    endfunction

    function automatic void take_edge(input edge_in_t e);
        int unsigned n;
        longint      sum;
        t_status     st;
        mst_result_t res;
        n = (nodes_cfg > MAX_NODES) ? MAX_NODES : nodes_cfg;
        if (stored_graph.size() >= MAX_EDGES) begin
            if (load_err < ST_OVERFLOW) load_err = ST_OVERFLOW;
        end else if (e.u == 0 || e.v == 0 || e.u > n || e.v > n) begin
            if (load_err < ST_BAD_ID) load_err = ST_BAD_ID;
        end else begin
            stored_graph.insert(stored_graph.size(), e);
        end
        if (e.last) begin
            if (load_err != ST_OK) begin
                sum = 0;
                st = load_err;
            end else begin
                prim_cost(n, sum, st);
            end
            res.total = (st == ST_OK) ? sum[TOTAL_W-1:0] : '0;
            res.status = st;
            mst_results_due.insert(mst_results_due.size(), res);
            stored_graph.delete();
            load_err = ST_OK;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                take_edge(edges_to_send.pop_front());
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (edges_to_send.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= IN_DATA_W'({edges_to_send[0].cost, edges_to_send[0].v,
                                             edges_to_send[0].u});
                    i_s_tlast <= edges_to_send[0].last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            hold_left <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        mst_result_t want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (mst_results_due.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result: total %0d status %0d",
                                 $signed(o_m_tdata[TOTAL_W-1:0]),
                                 o_m_tdata[TOTAL_W+ST_W-1:TOTAL_W]);
                    end
                    mismatch_count++;
                end else begin
                    want = mst_results_due.pop_front();
                    if (o_m_tdata[TOTAL_W-1:0] !== want.total ||
                        o_m_tdata[TOTAL_W+ST_W-1:TOTAL_W] !== want.status) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch: total %0d status %0d, expected %0d status %0d",
                                     $signed(o_m_tdata[TOTAL_W-1:0]),
                                     o_m_tdata[TOTAL_W+ST_W-1:TOTAL_W],
                                     $signed(want.total), want.status);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(32, 256);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end else begin
                pattern_left--;
            end
            i_m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic signed [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 7))
            0: return COST_NEVER;
            1: return 32'sh8000_0000;
            2, 3: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_edge(input int unsigned u, input int unsigned v,
                              input logic signed [COST_W-1:0] cost, input logic last);
        edge_in_t e;
        e.u = ID_W'(u);
        e.v = ID_W'(v);
        e.cost = cost;
        e.last = last;
        edges_to_send.insert(edges_to_send.size(), e);
    endtask

    task automatic write_node_count(input int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= ID_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        nodes_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every queued edge is taken and every result has come back.
    task automatic drain();
        while (edges_to_send.size() != 0 || i_s_tvalid || mst_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly connected graphs; some leave node n isolated, carry a bad id or are noise.
    task automatic queue_random_graph(input int unsigned n, output int unsigned count);
        edge_in_t    g[$];
        edge_in_t    e;
        int unsigned kind;
        int unsigned span;
        int unsigned extra;
        int unsigned bad;
        int          j;
        int          k;
        kind = $urandom_range(0, 9);
        span = (kind == 7) ? n - 1 : n;
        e.last = 1'b0;
        for (j = 2; j <= int'(span); j++) begin
            e.u = ID_W'(j);
            e.v = ID_W'($urandom_range(1, j - 1));
            if ($urandom_range(0, 1)) {e.u, e.v} = {e.v, e.u};
            e.cost = pick_cost();
            g.insert(g.size(), e);
        end
        extra = $urandom_range(0, span);
        for (j = 0; j < int'(extra); j++) begin
            e.u = ID_W'($urandom_range(1, span));
            e.v = ID_W'($urandom_range(1, span));
            e.cost = pick_cost();
            g.insert(g.size(), e);
        end
        if (g.size() == 0) begin
            e.u = ID_W'(1);
            e.v = ID_W'(1);
            e.cost = pick_cost();
            g.insert(g.size(), e);
        end
        if (kind == 8) begin
            k = $urandom_range(0, g.size() - 1);
            bad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(n + 1, MAX_ID);
            if ($urandom_range(0, 1)) g[k].u = ID_W'(bad);
            else g[k].v = ID_W'(bad);
        end else if (kind == 9) begin
            g.delete();
            for (j = 0; j < int'($urandom_range(1, 6)); j++) begin
                e.u = ID_W'($urandom_range(0, MAX_ID));
                e.v = ($urandom_range(0, 1)) ? ID_W'($urandom_range(0, MAX_ID))
                                             : ID_W'($urandom_range(1, n));
                e.cost = $urandom;
                g.insert(g.size(), e);
            end
        end
        for (j = g.size() - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            e = g[j];
            g[j] = g[k];
            g[k] = e;
        end
        g[g.size() - 1].last = 1'b1;
        count = g.size();
        foreach (g[i]) begin
            edges_to_send.insert(edges_to_send.size(), g[i]);
        end
    endtask

    initial begin
        int unsigned random_items;
        int unsigned phase_items;
        int unsigned graph_items;
        int unsigned n;
        int unsigned phase;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset node count of 2: cost extremes, the never-taken cost, self loop, bad ids.
        queue_edge(1, 2, 32'sh8000_0000, 1'b1);
        queue_edge(1, 2, COST_NEVER, 1'b1);
        queue_edge(1, 1, 5, 1'b0);
        queue_edge(2, 1, 7, 1'b1);
        queue_edge(0, 1, 3, 1'b1);
        queue_edge(1, 3, 3, 1'b0);
        queue_edge(1, 2, 4, 1'b1);
        queue_edge(MAX_ID, MAX_ID, -1, 1'b1);
        drain();

        write_node_count(1);
        queue_edge(1, 1, 9, 1'b1);
        queue_edge(1, 2, 1, 1'b1);
        drain();

        write_node_count(0);
        queue_edge(1, 1, 0, 1'b1);
        drain();

        // Above the node limit the count saturates; these graphs are not connected.
        write_node_count(MAX_ID);
        queue_edge(MAX_NODES, 1, 100, 1'b0);
        queue_edge(1, MAX_NODES, 50, 1'b1);
        queue_edge(MAX_NODES + 1, 1, 0, 1'b1);
        drain();

        write_node_count(MAX_NODES);
        queue_edge(MAX_NODES, 1, 5, 1'b0);
        queue_edge(1, 2, 3, 1'b1);
        drain();

        write_node_count(4);
        queue_edge(1, 2, -10, 1'b0);
        queue_edge(2, 3, COST_NEVER, 1'b0);
        queue_edge(3, 4, -5, 1'b0);
        queue_edge(1, 3, 20, 1'b1);
        queue_edge(1, 2, 32'sh8000_0000, 1'b0);
        queue_edge(3, 2, 32'sh8000_0000, 1'b0);
        queue_edge(4, 3, 32'sh8000_0000, 1'b1);
        queue_edge(1, 2, 32'sh7FFF_FFFE, 1'b0);
        queue_edge(2, 3, 32'sh7FFF_FFFE, 1'b0);
        queue_edge(3, 4, 32'sh7FFF_FFFE, 1'b1);
        drain();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: n = 2;
                1: n = 3;
                default: n = $urandom_range(4, 12);
            endcase
            write_node_count(n);
            if (phase == 2) begin
                long_hold_req = 1'b1;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                queue_random_graph(n, graph_items);
                phase_items += graph_items;
            end
            random_items += phase_items;
            drain();
            phase++;
        end

        if (mismatch_count == 0 && mst_results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ prim_mst_total_cost.f @@
+incdir+rtl
rtl/pmst_pkg.sv
rtl/pmst_edge_store.sv
rtl/pmst_tree_map.sv
rtl/pmst_best_sel.sv
rtl/prim_mst_total_cost.sv
verif/tb_top.sv
